/* hw/rtl/sde_pkg.sv */
`timescale 1ns / 1ps

package sde_pkg;

    // field widths
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 21;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 24;
    localparam int ACC_W   = 10;
    localparam int PEND_W  = 4;
    localparam int DIGIT_W = 3;
    localparam int TAKE_W  = 2;
    localparam int SH_W    = 2;

    // payload limits
    localparam int MAX_PAYLOAD_BYTES = 1048576;
    localparam int SKIP_THRESH       = 250;
    localparam int BITS_PER_BYTE     = 8;

    // reciprocal for the decimal digit: q = (v * 205) >> 11, exact below 1029
    localparam int RECIP_MUL   = 205;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = 16;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // item held in the input register
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel_value;
        logic              first_of_image;
    } stage_t;

    // last decimal digit of a channel byte, cut to 3 bits
    function automatic logic [DIGIT_W-1:0] low_digit(input logic [CHAN_W-1:0] v);
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        logic [CHAN_W-1:0] rem;
        prod = PROD_W'(v) * PROD_W'(RECIP_MUL);
        quot = prod[PROD_W-1:RECIP_SHIFT];
        rem  = v - CHAN_W'(CHAN_W'(quot) * CHAN_W'(10));
        return rem[DIGIT_W-1:0];
    endfunction

endpackage

/* hw/rtl/sde_if.sv */
`timescale 1ns / 1ps

// channel byte stream
interface sde_in_if;
    logic                       valid;
    logic                       ready;
    logic [sde_pkg::CHAN_W-1:0] channel_value;
    logic                       first_of_image;

    modport source (output valid, output channel_value, output first_of_image, input ready);
    modport sink (input valid, input channel_value, input first_of_image, output ready);
endinterface

// recovered byte stream
interface sde_out_if;
    logic                       valid;
    logic                       ready;
    logic [sde_pkg::BYTE_W-1:0] payload_byte;
    logic                       last_byte;

    modport source (output valid, output payload_byte, output last_byte, input ready);
    modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

// length register write channel
interface sde_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [sde_pkg::CFG_W-1:0] payload_bytes;

    modport source (output valid, output payload_bytes, input ready);
    modport sink (input valid, input payload_bytes, output ready);
endinterface

/* hw/rtl/sde_in_stage.sv */
`timescale 1ns / 1ps

module sde_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    sde_in_if.sink          pixel,
    input  logic            advance,
    output sde_pkg::stage_t stage
);
    import sde_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAN_W-1:0] value_reg;
    logic              first_reg;
    logic              accept;

    // free when empty or when the held item moves on this cycle
    assign pixel.ready = !valid_reg || advance;
    assign accept      = pixel.valid && pixel.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= pixel.channel_value;
            first_reg <= pixel.first_of_image;
        end
    end

    assign stage.valid          = valid_reg;
    assign stage.channel_value  = value_reg;
    assign stage.first_of_image = first_reg;

endmodule

/* hw/rtl/sde_extract.sv */
`timescale 1ns / 1ps

module sde_extract (
    input  logic            clk,
    input  logic            rst_n,
    input  sde_pkg::stage_t stage,
    output logic            advance,
    sde_cfg_if.sink         cfg,
    sde_out_if.source       recovered
);
    import sde_pkg::*;

    logic [CFG_W-1:0]   payload_bytes_reg;
    logic [ACC_W-1:0]   acc_reg,      acc_next;
    logic [PEND_W-1:0]  pend_reg,     pend_next;
    logic [TOTAL_W-1:0] gathered_reg, gathered_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               last_reg;

    logic [CFG_W-1:0]       clamped;
    logic [TOTAL_W-1:0]     total;
    logic [ACC_W-1:0]       eff_acc;
    logic [PEND_W-1:0]      eff_pend;
    logic [TOTAL_W-1:0]     eff_gathered;
    logic [TOTAL_W-1:0]     need;
    logic                   active;
    logic [DIGIT_W-1:0]     digit;
    logic [TAKE_W-1:0]      take;
    logic [DIGIT_W-1:0]     bits;
    logic [ACC_W+DIGIT_W-1:0] acc_wide;
    logic [ACC_W-1:0]       acc_new;
    logic [PEND_W-1:0]      pend_sum;
    logic [TOTAL_W-1:0]     gathered_sum;
    logic                   emit;
    logic [SH_W-1:0]        sh;
    logic [ACC_W-1:0]       acc_shifted;
    logic [ACC_W-1:0]       acc_mask;

    // length register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_bytes_reg <= '0;
        end
        else if (cfg.valid)
        begin
            payload_bytes_reg <= cfg.payload_bytes;
        end
    end

    // bit budget for the image
    assign clamped = (payload_bytes_reg > CFG_W'(MAX_PAYLOAD_BYTES)) ?
                     CFG_W'(MAX_PAYLOAD_BYTES) : payload_bytes_reg;
    assign total   = TOTAL_W'(clamped) << $clog2(BITS_PER_BYTE);

    // a new image starts from cleared state
    assign eff_acc      = stage.first_of_image ? '0 : acc_reg;
    assign eff_pend     = stage.first_of_image ? '0 : pend_reg;
    assign eff_gathered = stage.first_of_image ? '0 : gathered_reg;

    assign active = (eff_gathered < total) && (stage.channel_value < CHAN_W'(SKIP_THRESH));
    assign need   = total - eff_gathered;
    assign digit  = low_digit(stage.channel_value);

    // group size and bits, narrower near the end of the payload
    always_comb
    begin
        if (need >= TOTAL_W'(3))
        begin
            take = TAKE_W'(3);
            bits = digit;
        end
        else if (need == TOTAL_W'(2))
        begin
            take = TAKE_W'(2);
            bits = {1'b0, digit[1:0]};
        end
        else
        begin
            take = TAKE_W'(1);
            bits = {2'b00, (digit == DIGIT_W'(1))};
        end
    end

    // append and split off a finished byte
    assign acc_wide     = ((ACC_W+DIGIT_W)'(eff_acc) << take) | (ACC_W+DIGIT_W)'(bits);
    assign acc_new      = acc_wide[ACC_W-1:0];
    assign pend_sum     = eff_pend + PEND_W'(take);
    assign gathered_sum = eff_gathered + TOTAL_W'(take);
    assign emit         = active && (pend_sum >= PEND_W'(BITS_PER_BYTE));
    assign sh           = SH_W'(pend_sum - PEND_W'(BITS_PER_BYTE));
    assign acc_shifted  = acc_new >> sh;
    assign acc_mask     = (ACC_W'(1) << sh) - ACC_W'(1);

    // item moves on when the result register is free or draining
    assign advance = stage.valid && (!out_valid_reg || recovered.ready);

    always_comb
    begin
        acc_next      = acc_reg;
        pend_next     = pend_reg;
        gathered_next = gathered_reg;
        if (advance)
        begin
            if (active)
            begin
                gathered_next = gathered_sum;
                if (emit)
                begin
                    acc_next  = acc_new & acc_mask;
                    pend_next = PEND_W'(sh);
                end
                else
                begin
                    acc_next  = acc_new;
                    pend_next = pend_sum;
                end
            end
            else
            begin
                acc_next      = eff_acc;
                pend_next     = eff_pend;
                gathered_next = eff_gathered;
            end
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (recovered.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            gathered_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            gathered_reg  <= gathered_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            byte_reg <= acc_shifted[BYTE_W-1:0];
            last_reg <= (gathered_sum >= total);
        end
    end

    assign recovered.valid        = out_valid_reg;
    assign recovered.payload_byte = byte_reg;
    assign recovered.last_byte    = last_reg;

endmodule

/* hw/rtl/stego_digit_extract_top.sv */
`timescale 1ns / 1ps

// channel    dir  payload                              handshake
// pixel      in   channel_value[8], first_of_image[1]  valid/ready
// recovered  out  payload_byte[8], last_byte[1]        valid/ready
// cfg        in   payload_bytes[21]                    valid/ready, ready always high
//
// one channel byte accepted per cycle while recovered is not stalled; an item is held in the
// input register, then its result is registered in the result register and offered from there
// the per-byte state update (digit, append, byte split) is combinational from the input register
// rst_n clears the length register, bit accumulator and all valid flags
// a stalled recovered holds one item in the result register and one in the input
// register; pixel.ready drops only while both are full

module stego_digit_extract_top (
    input  logic      clk,
    input  logic      rst_n,
    sde_in_if.sink    pixel,
    sde_out_if.source recovered,
    sde_cfg_if.sink   cfg
);
    import sde_pkg::*;

    stage_t stage;
    logic   advance;

    // input register
    sde_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel),
        .advance (advance),
        .stage   (stage)
    );

    // digit extraction, state and result register
    sde_extract u_extract (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .advance   (advance),
        .cfg       (cfg),
        .recovered (recovered)
    );

endmodule

/* hw/rtl/sde_checker.sv */
`timescale 1ns / 1ps

module sde_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pix_valid,
    input logic                       pix_ready,
    input logic                       rec_valid,
    input logic                       rec_ready,
    input logic [sde_pkg::BYTE_W-1:0] rec_byte,
    input logic                       rec_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec_byte) && $stable(rec_last))
        else $error("stalled result changed");

    // input backpressure only when the output side is blocked
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> rec_valid && !rec_ready)
        else $error("input stalled while output free");

    // a fresh result follows an accepted input item, via the input and result registers
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rec_valid) |-> $past(pix_valid && pix_ready, 2))
        else $error("result without a matching input item");

endmodule

bind stego_digit_extract_top sde_checker u_sde_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .rec_valid (recovered.valid),
    .rec_ready (recovered.ready),
    .rec_byte  (recovered.payload_byte),
    .rec_last  (recovered.last_byte)
);

/* dv/stego_digit_extract_top_test.sv */
`timescale 1ns / 1ps

module stego_digit_extract_top_test;
    import sde_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int N_PHASES      = 8;
    localparam int N_DIR         = 30;
    localparam int HOLD_CYCLES   = 120;

    typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

    // one directed row: a length write or a channel byte, optionally with a typed result
    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_W-1:0]  val;
        logic              first;
        logic              typed;
        logic [BYTE_W-1:0] tbyte;
        logic              tlast;
    } dir_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pbyte;
        logic              last;
    } recovered_t;

    dir_row_t dir_rows [N_DIR] = '{
        '{ROW_CFG, 21'd0,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd5,       1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd123,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, 21'd1,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd255,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd250,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd249,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd0,       1'b0, 1'b1, 8'hE4, 1'b1},
        '{ROW_PIX, 21'd1,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd8,       1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd6,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd3,       1'b0, 1'b1, 8'h1B, 1'b1},
        '{ROW_CFG, 21'd2,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b0, 1'b1, 8'hFF, 1'b0},
        '{ROW_PIX, 21'd0,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd0,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd9,       1'b0, 1'b1, 8'h81, 1'b1},
        '{ROW_CFG, 21'd3,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd7,       1'b0, 1'b1, 8'hFF, 1'b0},
        '{ROW_CFG, 21'd1,       1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd100,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, 21'd2097151, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd249,     1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd248,     1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_PIX, 21'd247,     1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    sde_in_if  pixel ();
    sde_out_if recovered ();
    sde_cfg_if cfg ();

    stego_digit_extract_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .recovered (recovered),
        .cfg       (cfg)
    );

    // predictor state
    logic [CFG_W-1:0]   length_reg;
    logic [ACC_W-1:0]   acc_bits;
    logic [PEND_W-1:0]  acc_count;
    logic [TOTAL_W-1:0] image_bits;

    recovered_t awaited_bytes [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int bytes_seen   = 0;
    int length_writes = 0;
    int send_idle_pct = 0;
    int stall_pct    = 0;
    int holds_asked  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // append the bits of one channel byte; returns 1 when a byte completes
    function automatic bit recover_byte(input logic [CHAN_W-1:0] v, input logic f,
                                        output logic [BYTE_W-1:0] pb, output logic pl);
        int unsigned total;
        int unsigned need;
        int unsigned take;
        int unsigned sh;
        logic [DIGIT_W-1:0] digit;
        logic [DIGIT_W-1:0] grp;
        pb = '0;
        pl = 1'b0;
        if (f)
        begin
            acc_bits   = '0;
            acc_count  = '0;
            image_bits = '0;
        end
        total = (length_reg > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : length_reg;
        total = total * BITS_PER_BYTE;
        if (image_bits >= total || v >= SKIP_THRESH)
            return 1'b0;
        digit = DIGIT_W'(int'(v) % 10);
        need  = total - image_bits;
        if (need >= 3)
        begin
            take = 3;
            grp  = digit;
        end
        else if (need == 2)
        begin
            take = 2;
            grp  = {1'b0, digit[1:0]};
        end
        else
        begin
            take = 1;
            grp  = (digit == 3'd1) ? 3'd1 : 3'd0;
        end
        acc_bits   = (acc_bits << take) | ACC_W'(grp);
        acc_count  = acc_count + PEND_W'(take);
        image_bits = image_bits + TOTAL_W'(take);
        if (acc_count < BITS_PER_BYTE)
            return 1'b0;
        sh        = acc_count - BITS_PER_BYTE;
        pb        = BYTE_W'(acc_bits >> sh);
        pl        = (image_bits >= total);
        acc_count = PEND_W'(sh);
        acc_bits  = acc_bits & ACC_W'((1 << sh) - 1);
        return 1'b1;
    endfunction

    // offer one channel byte, predict at acceptance
    task automatic send_pixel(input logic [CHAN_W-1:0] v, input logic f, input logic typed,
                              input logic [BYTE_W-1:0] tb, input logic tl);
        logic [BYTE_W-1:0] pb;
        logic pl;
        bit has;
        recovered_t item;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            pixel.valid <= 1'b0;
            @(negedge clk);
        end
        pixel.valid          <= 1'b1;
        pixel.channel_value  <= v;
        pixel.first_of_image <= f;
        do
        begin
            @(posedge clk);
        end
        while (!pixel.ready);
        has = recover_byte(v, f, pb, pl);
        if (typed || has)
        begin
            item          = typed ? recovered_t'{tb, tl} : recovered_t'{pb, pl};
            awaited_bytes = {awaited_bytes, item};
        end
        items_sent++;
    endtask

    // stop offering and wait for every expected byte, then let the pipe settle
    task automatic drain_results();
        @(negedge clk);
        pixel.valid <= 1'b0;
        while (awaited_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // length write, only with the block idle
    task automatic write_length(input logic [CFG_W-1:0] val);
        drain_results();
        @(negedge clk);
        cfg.valid         <= 1'b1;
        cfg.payload_bytes <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        length_reg = val;
        length_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left       = 0;
        holds_done      = 0;
        recovered.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                recovered.ready <= 1'b0;
                hold_left--;
            end
            else
                recovered.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each accepted byte with the oldest expectation
    always @(posedge clk)
    begin
        recovered_t exp_item;
        if (rst_n && recovered.valid && recovered.ready)
        begin
            bytes_seen++;
            if (awaited_bytes.size() == 0)
            begin
                $display("%0t: unexpected item payload_byte %02h last_byte %0b", $time,
                         recovered.payload_byte, recovered.last_byte);
                fail_count++;
            end
            else
            begin
                exp_item = awaited_bytes.pop_front();
                if (recovered.payload_byte !== exp_item.pbyte)
                begin
                    $display("%0t: payload_byte expected %02h actual %02h", $time,
                             exp_item.pbyte, recovered.payload_byte);
                    fail_count++;
                end
                if (recovered.last_byte !== exp_item.last)
                begin
                    $display("%0t: last_byte expected %0b actual %0b", $time,
                             exp_item.last, recovered.last_byte);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned phase_len [N_PHASES];
        int unsigned eff_len;
        int img_left;
        int img_max;
        int mode;
        logic f;
        logic [CHAN_W-1:0] v;

        rst_n                = 1'b0;
        pixel.valid          = 1'b0;
        pixel.channel_value  = '0;
        pixel.first_of_image = 1'b0;
        cfg.valid            = 1'b0;
        cfg.payload_bytes    = '0;
        length_reg           = '0;
        acc_bits             = '0;
        acc_count            = '0;
        image_bits           = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < N_DIR; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_length(dir_rows[r].val);
            else
                send_pixel(dir_rows[r].val[CHAN_W-1:0], dir_rows[r].first, dir_rows[r].typed,
                           dir_rows[r].tbyte, dir_rows[r].tlast);
        end

        // random images, one length and one idling pattern per phase
        phase_len = '{1, 3, $urandom_range(4, 40), MAX_PAYLOAD_BYTES, 7, 2097151,
                      $urandom_range(1, 2), 2};
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_length(CFG_W'(phase_len[p]));
            mode          = p % 4;
            send_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 35 : 0;
            stall_pct     = (mode == 2) ? 56 : (mode == 3) ? 35 : 0;
            eff_len       = (phase_len[p] > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                               : phase_len[p];
            img_max       = (eff_len > 60) ? 200 : 3 * eff_len + 12;
            img_left      = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // receiver holds off while the sender keeps offering
                if (mode == 0 && i == 60)
                    holds_asked++;
                // sender pauses until all results are in
                if (mode == 1 && i == 125)
                    drain_results();
                f = 1'b0;
                if (img_left == 0)
                begin
                    f        = 1'b1;
                    img_left = $urandom_range(4, img_max);
                end
                else if ($urandom_range(0, 99) < 4)
                    f = 1'b1;
                img_left--;
                if ($urandom_range(0, 99) < 10)
                    v = CHAN_W'($urandom_range(250, 255));
                else
                    v = CHAN_W'($urandom_range(0, 249));
                send_pixel(v, f, 1'b0, '0, 1'b0);
            end
        end

        drain_results();
        $display("sent %0d channel bytes over %0d length settings, zero and oversized included",
                 items_sent, length_writes);
        $display("checked %0d recovered bytes under mixed sender gaps and receiver stalls",
                 bytes_seen);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
